// ===== src/swept_box_slab_test_unit_defines.svh =====
// Assertion macros shared by the swept box slab test checker
`ifndef SWEPT_BOX_SLAB_TEST_UNIT_DEFINES_SVH
`define SWEPT_BOX_SLAB_TEST_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define SBST_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swept box slab test check failed");

// next-cycle implication, held off during reset
`define SBST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swept box slab test check failed");

`endif

// ===== src/sbst_pkg.sv =====
// Shared constants and register codes for the swept box slab test
`default_nettype none
package sbst_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int NUM_AXES        = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_X   = 3'd0,
		CFG_START_Y   = 3'd1,
		CFG_START_Z   = 3'd2,
		CFG_INV_VEL_X = 3'd3,
		CFG_INV_VEL_Y = 3'd4,
		CFG_INV_VEL_Z = 3'd5
	} cfg_reg_t;

endpackage
`default_nettype wire

// ===== src/sbst_axis.sv =====
// One axis of the slab test: grown faces, scaled slab times, entry and exit order
`default_nettype none
module sbst_axis
	import sbst_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic signed [COORD_WIDTH-1:0] box_min,
	input  wire logic signed [COORD_WIDTH-1:0] box_max,
	input  wire logic        [COORD_WIDTH-2:0] half_size,
	input  wire logic signed [COORD_WIDTH-1:0] start,
	input  wire logic signed [COORD_WIDTH-1:0] inv_vel,
	output logic      signed [COORD_WIDTH-1:0] t_entry,
	output logic      signed [COORD_WIDTH-1:0] t_exit
);

	localparam int DW  = COORD_WIDTH + 2;
	localparam int H   = COORD_WIDTH / 2;
	localparam int KHW = COORD_WIDTH - H;
	localparam int PLW = DW + H + 1;
	localparam int PHW = DW + KHW;
	localparam int PW  = DW + COORD_WIDTH;

	localparam logic signed [COORD_WIDTH-1:0] SMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] SMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [PW-1:0] SMAX_P = PW'(SMAX);
	localparam logic signed [PW-1:0] SMIN_P = PW'(SMIN);

	logic signed [DW-1:0]  bmin_e, bmax_e, half_e, start_e;
	logic signed [DW-1:0]  dmin_s2, dmax_s2;
	logic signed [H:0]     k_lo;
	logic signed [KHW-1:0] k_hi;
	logic signed [PLW-1:0] plo_min_s3, plo_max_s3;
	logic signed [PHW-1:0] phi_min_s3, phi_max_s3;
	logic signed [PW-1:0]  full_min, full_max, scl_min, scl_max;
	logic signed [COORD_WIDTH-1:0] tmin_s4, tmax_s4, sat_min, sat_max;

	// grow the box and offset by the start point, exactly
	assign bmin_e  = DW'(box_min);
	assign bmax_e  = DW'(box_max);
	assign half_e  = DW'($signed({1'b0, half_size}));
	assign start_e = DW'(start);

	always_ff @(posedge clk) begin
		dmin_s2 <= bmin_e - half_e - start_e;
		dmax_s2 <= bmax_e + half_e - start_e;
	end

	// split the inverse velocity into two halves for narrower products
	assign k_lo = $signed({1'b0, inv_vel[H-1:0]});
	assign k_hi = inv_vel[COORD_WIDTH-1:H];

	always_ff @(posedge clk) begin
		plo_min_s3 <= PLW'(dmin_s2) * PLW'(k_lo);
		plo_max_s3 <= PLW'(dmax_s2) * PLW'(k_lo);
		phi_min_s3 <= PHW'(dmin_s2) * PHW'(k_hi);
		phi_max_s3 <= PHW'(dmax_s2) * PHW'(k_hi);
	end

	// recombine, floor shift, saturate
	always_comb begin
		full_min = (PW'(phi_min_s3) <<< H) + PW'(plo_min_s3);
		full_max = (PW'(phi_max_s3) <<< H) + PW'(plo_max_s3);
		scl_min  = full_min >>> FRAC_BITS;
		scl_max  = full_max >>> FRAC_BITS;
		if (scl_min > SMAX_P) begin
			sat_min = SMAX;
		end else if (scl_min < SMIN_P) begin
			sat_min = SMIN;
		end else begin
			sat_min = scl_min[COORD_WIDTH-1:0];
		end
		if (scl_max > SMAX_P) begin
			sat_max = SMAX;
		end else if (scl_max < SMIN_P) begin
			sat_max = SMIN;
		end else begin
			sat_max = scl_max[COORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		tmin_s4 <= sat_min;
		tmax_s4 <= sat_max;
	end

	// order into entry and exit
	always_ff @(posedge clk) begin
		if (tmin_s4 < tmax_s4) begin
			t_entry <= tmin_s4;
			t_exit  <= tmax_s4;
		end else begin
			t_entry <= tmax_s4;
			t_exit  <= tmin_s4;
		end
	end

endmodule
`default_nettype wire

// ===== src/swept_box_slab_test_unit.sv =====
// Top level of the swept box slab test: config registers, input capture, clipping
`default_nettype none
// Usage:
//   Command channel: drive the box corners, half extents and the incoming
//   interval with start high; a beat is taken at every rising edge where
//   start is high and busy is low. busy stays low, so a new beat may be
//   offered in every cycle.
//   Result channel: done is high for one cycle with hit, range_out_low and
//   range_out_high; the receiver takes the beat at the end of that cycle and
//   cannot hold it off.
//   Pipeline: a result passes through eight register stages (capture, face
//   offset, partial products, recombine and saturate, ordering, two clip
//   levels, output).
//   Throughput: one beat per cycle, results in command order.
//   Configuration: cfg_we with cfg_idx and cfg_data writes the start point
//   (indices 0 to 2) or the inverse velocity (indices 3 to 5) at that edge;
//   other indices are dropped. Write only while no beat is in flight.
//   Reset: arst_n clears the stage valids and done, sets the start point to
//   zero and each inverse velocity to one.
module swept_box_slab_test_unit
	import sbst_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic        [CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic        [COORD_WIDTH-1:0] cfg_data,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] box_min_x,
	input  wire logic signed [COORD_WIDTH-1:0] box_min_y,
	input  wire logic signed [COORD_WIDTH-1:0] box_min_z,
	input  wire logic signed [COORD_WIDTH-1:0] box_max_x,
	input  wire logic signed [COORD_WIDTH-1:0] box_max_y,
	input  wire logic signed [COORD_WIDTH-1:0] box_max_z,
	input  wire logic        [COORD_WIDTH-2:0] half_size_x,
	input  wire logic        [COORD_WIDTH-2:0] half_size_y,
	input  wire logic        [COORD_WIDTH-2:0] half_size_z,
	input  wire logic signed [COORD_WIDTH-1:0] range_in_low,
	input  wire logic signed [COORD_WIDTH-1:0] range_in_high,
	output logic                               done,
	output logic                               hit,
	output logic      signed [COORD_WIDTH-1:0] range_out_low,
	output logic      signed [COORD_WIDTH-1:0] range_out_high
);

	localparam logic signed [COORD_WIDTH-1:0] ONE = COORD_WIDTH'(1) << FRAC_BITS;

	logic signed [COORD_WIDTH-1:0] start_q [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] inv_q   [NUM_AXES];

	logic                          accept;
	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [COORD_WIDTH-1:0] bmin_s1 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] bmax_s1 [NUM_AXES];
	logic        [COORD_WIDTH-2:0] half_s1 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] lo_s1, lo_s2, lo_s3, lo_s4, lo_s5;
	logic signed [COORD_WIDTH-1:0] hi_s1, hi_s2, hi_s3, hi_s4, hi_s5;
	logic signed [COORD_WIDTH-1:0] t_entry [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] t_exit  [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] lo_a_s6, lo_b_s6, hi_a_s6, hi_b_s6;
	logic signed [COORD_WIDTH-1:0] lo_s7, hi_s7;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				start_q[i] <= '0;
				inv_q[i]   <= ONE;
			end
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_START_X:   start_q[0] <= cfg_data;
				CFG_START_Y:   start_q[1] <= cfg_data;
				CFG_START_Z:   start_q[2] <= cfg_data;
				CFG_INV_VEL_X: inv_q[0]   <= cfg_data;
				CFG_INV_VEL_Y: inv_q[1]   <= cfg_data;
				CFG_INV_VEL_Z: inv_q[2]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			done   <= vld_s7;
		end
	end

	// capture the command beat
	always_ff @(posedge clk) begin
		bmin_s1[0] <= box_min_x;
		bmin_s1[1] <= box_min_y;
		bmin_s1[2] <= box_min_z;
		bmax_s1[0] <= box_max_x;
		bmax_s1[1] <= box_max_y;
		bmax_s1[2] <= box_max_z;
		half_s1[0] <= half_size_x;
		half_s1[1] <= half_size_y;
		half_s1[2] <= half_size_z;
		lo_s1      <= range_in_low;
		hi_s1      <= range_in_high;
	end

	// carry the incoming interval alongside the axis pipelines
	always_ff @(posedge clk) begin
		lo_s2 <= lo_s1;
		lo_s3 <= lo_s2;
		lo_s4 <= lo_s3;
		lo_s5 <= lo_s4;
		hi_s2 <= hi_s1;
		hi_s3 <= hi_s2;
		hi_s4 <= hi_s3;
		hi_s5 <= hi_s4;
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		sbst_axis #(
			.COORD_WIDTH(COORD_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_axis (
			.clk      (clk),
			.box_min  (bmin_s1[a]),
			.box_max  (bmax_s1[a]),
			.half_size(half_s1[a]),
			.start    (start_q[a]),
			.inv_vel  (inv_q[a]),
			.t_entry  (t_entry[a]),
			.t_exit   (t_exit[a])
		);
	end

	// clip: latest entry, earliest exit, in two levels
	always_ff @(posedge clk) begin
		lo_a_s6 <= (t_entry[0] > lo_s5) ? t_entry[0] : lo_s5;
		lo_b_s6 <= (t_entry[1] > t_entry[2]) ? t_entry[1] : t_entry[2];
		hi_a_s6 <= (t_exit[0] < hi_s5) ? t_exit[0] : hi_s5;
		hi_b_s6 <= (t_exit[1] < t_exit[2]) ? t_exit[1] : t_exit[2];
	end

	always_ff @(posedge clk) begin
		lo_s7 <= (lo_a_s6 > lo_b_s6) ? lo_a_s6 : lo_b_s6;
		hi_s7 <= (hi_a_s6 < hi_b_s6) ? hi_a_s6 : hi_b_s6;
	end

	always_ff @(posedge clk) begin
		range_out_low  <= lo_s7;
		range_out_high <= hi_s7;
		hit            <= (lo_s7 <= hi_s7);
	end

endmodule
`default_nettype wire

// ===== src/sbst_checker.sv =====
// Port-level checks for the swept box slab test, bound to its top level
`default_nettype none
`include "swept_box_slab_test_unit_defines.svh"
module sbst_checker
	import sbst_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic signed [COORD_WIDTH-1:0] range_in_low,
	input  wire logic signed [COORD_WIDTH-1:0] range_in_high,
	input  wire logic                          done,
	input  wire logic                          hit,
	input  wire logic signed [COORD_WIDTH-1:0] range_out_low,
	input  wire logic signed [COORD_WIDTH-1:0] range_out_high
);

	`SBST_ASSERT_NEXT(a_beat_gives_result, start && !busy, ##7 done)
	`SBST_ASSERT_IMPL(a_result_has_beat, done, $past(start && !busy, 8))
	`SBST_ASSERT_IMPL(a_hit_matches_range, done, hit == (range_out_low <= range_out_high))
	`SBST_ASSERT_IMPL(a_low_not_below_in, done, range_out_low >= $past(range_in_low, 8))
	`SBST_ASSERT_IMPL(a_high_not_above_in, done, range_out_high <= $past(range_in_high, 8))

endmodule

bind swept_box_slab_test_unit sbst_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sbst_checker (.*);
`default_nettype wire
